// File: design/hsfc_pkg.sv
package hsfc_pkg;

  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_t;

  localparam int unsigned HalfBias   = 15;
  localparam int unsigned SingleBias = 127;
  localparam logic [7:0]  ExpRebias  = 8'd112;

  typedef struct packed {
    op_t         operation;
    logic [31:0] value;
  } in_item_t;

endpackage

// File: design/hsfc_stream_if.sv
interface hsfc_stream_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/half_single_float_converter.sv
// Channel  | dir | payload
// ---------+-----+--------------------------------------------
// in_ch    | in  | data[32] = operation, data[31:0] = value
// out_ch   | out | data[31:0] = converted
//
// One item per cycle unless out_ch stalls; items pass the input register, then the result register.
// The input register holds when the result register is stalled, and a new
// item enters whenever the input register is empty or the result register is empty or draining.
// rst clears the valid flags only; no state survives an item.
module half_single_float_converter
  import hsfc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  hsfc_stream_if.sink   in_ch,
  hsfc_stream_if.source out_ch
);

  logic        in_valid;
  in_item_t    in_item;
  logic        out_valid;
  logic [31:0] out_data;
  logic        out_load;
  logic        in_load;
  logic [31:0] result;

  assign out_load     = !out_valid || out_ch.ready;
  assign in_load      = !in_valid || out_load;
  assign in_ch.ready  = in_load;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= in_ch.valid;
    end
    if (in_load && in_ch.valid) begin
      in_item <= in_item_t'(in_ch.data);
    end
  end

  // Conversion logic
  logic        h_sign;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  lead;
  logic [22:0] sub_man;
  logic [31:0] wide;
  logic        s_sign;
  logic [7:0]  s_exp;
  logic [22:0] s_man;
  logic [4:0]  sh;
  logic [23:0] sub_h;
  logic [4:0]  n_exp;
  logic [9:0]  n_man;

  always_comb begin
    h_sign = in_item.value[15];
    h_exp  = in_item.value[14:10];
    h_man  = in_item.value[9:0];
    lead   = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (h_man[k]) lead = 4'(k);
    end
    sub_man = 23'({13'd0, h_man} << (5'd23 - 5'(lead)));
    if (h_exp == 5'd0) begin
      if (h_man == 10'd0) wide = 32'd0;
      else wide = {h_sign, 8'(lead) + 8'd103, sub_man};
    end else if (h_exp == 5'h1f) begin
      wide = {h_sign, 8'hff, 22'd0, h_man != 10'd0};
    end else begin
      wide = {h_sign, 8'(h_exp) + ExpRebias, h_man, 13'd0};
    end

    s_sign = in_item.value[31];
    s_exp  = in_item.value[30:23];
    s_man  = in_item.value[22:0];
    // exp 103..112 -> shift (126 - exp) = 14..23
    sh     = 5'(8'd126 - s_exp);
    sub_h  = {1'b1, s_man} >> sh;
    n_exp  = 5'd0;
    n_man  = 10'd0;
    if (s_exp == 8'd0) begin
      n_exp = 5'd0;
    end else if (s_exp == 8'hff) begin
      n_exp = 5'h1f;
      n_man = {9'd0, s_man != 23'd0};
    end else if (s_exp < 8'd103) begin
      n_exp = 5'd0;
    end else if (s_exp < 8'd113) begin
      n_man = sub_h[9:0];
    end else if (s_exp > 8'd142) begin
      n_exp = 5'h1f;
    end else begin
      n_exp = 5'(s_exp - 8'd112);
      n_man = s_man[22:13];
    end

    result = (in_item.operation == OP_H2S) ? wide : {16'd0, s_sign, n_exp, n_man};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
    if (out_load && in_valid) begin
      out_data <= result;
    end
  end

endmodule

// File: design/hsfc_checker.sv
module hsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [32:0] in_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Half results keep the upper bits clear
  a_upper: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data[32] && out_ready |-> ##2
      (!out_valid || out_data[31:16] == 16'd0 || !$past(out_ready)))
    else $error("half result has upper bits set");

  // Input is taken whenever the output side drains
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // An accepted item reaches the output through the input and result registers when out_ready stays high
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
    else $error("item lost");

endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_data   (in_ch.data),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
